>>> rtl/spta_pkg.sv
// Package with the shared types and constants of the SPTA stepper ramp generator.
`timescale 1ns / 1ps
package spta_pkg;

  localparam int unsigned PhaseAccW = 16;
  localparam int unsigned SpeedW    = 17;
  localparam int unsigned RateW     = 24;
  localparam int unsigned CountW    = 32;
  localparam int unsigned MoveW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ACCEL = 3'd1;
  localparam logic [2:0] PH_MAX   = 3'd2;
  localparam logic [2:0] PH_DECEL = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_UP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_DOWN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_MODE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GUARD      = 3'd4;

  localparam logic [CountW-1:0] GUARD_MARGIN    = 32'd600;
  localparam logic [SpeedW-1:0] SPEED_TOLERANCE = 17'd3;
  localparam logic [SpeedW-1:0] SPEED_FALLBACK  = 17'd20000;

  typedef struct packed {
    logic             kind;
    logic             direction;
    logic [MoveW-1:0] step_total;
  } in_item_t;

  typedef struct packed {
    logic                     step_pulse;
    logic signed [CountW-1:0] position;
    logic [2:0]               phase;
    logic                     running;
    logic                     guard_tripped;
    logic [SpeedW-1:0]        current_speed;
  } out_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] max_speed;
    logic [RateW-1:0]  accel_rate_up;
    logic [RateW-1:0]  accel_rate_down;
    logic              speed_mode;
    logic              overrun_guard;
  } cfg_t;

endpackage

>>> rtl/spta_cfg_regs.sv
// Configuration register file of the SPTA stepper ramp generator.
`timescale 1ns / 1ps
module spta_cfg_regs
  import spta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED:  cfg_r.max_speed       <= cfg_wdata[SpeedW-1:0];
        CFG_ACCEL_UP:   cfg_r.accel_rate_up   <= cfg_wdata[RateW-1:0];
        CFG_ACCEL_DOWN: cfg_r.accel_rate_down <= cfg_wdata[RateW-1:0];
        CFG_SPEED_MODE: cfg_r.speed_mode      <= cfg_wdata[0];
        CFG_GUARD:      cfg_r.overrun_guard   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/spta_core.sv
// Motion state registers and the per-beat ramp, step and phase update logic.
`timescale 1ns / 1ps
module spta_core
  import spta_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  logic [2:0]           phase_r, phase_nxt;
  logic [PhaseAccW-1:0] pacc_r, pacc_nxt;
  logic [SpeedW-1:0]    sacc_r, sacc_nxt;
  logic [SpeedW-1:0]    speed_r, speed_nxt;
  logic [CountW-1:0]    steps_r, steps_nxt;
  logic [CountW-1:0]    ramp_r, ramp_nxt;
  logic [MoveW-1:0]     mlen_r, mlen_nxt;
  logic [MoveW-2:0]     mhalf_r, mhalf_nxt;
  logic [CountW-1:0]    pos_r, pos_nxt;
  logic                 dir_r, dir_nxt;
  logic                 busy_r, busy_nxt;
  logic [SpeedW-1:0]    tgt_r, tgt_nxt;
  logic [RateW-1:0]     up_r, up_nxt;
  logic [RateW-1:0]     dn_r, dn_nxt;
  logic                 smode_r, smode_nxt;
  logic                 guard_r, guard_nxt;
  logic                 gflag_r, gflag_nxt;

  logic [PhaseAccW+1:0] psum;
  logic                 carry;
  logic [CountW-1:0]    steps_inc;
  logic                 guard_hit;
  logic [2:0]           phase_g;
  logic                 smode_g;
  logic [CountW-1:0]    remaining;
  logic                 short_left;
  logic [SpeedW-1:0]    diff;
  logic                 in_band;
  logic [RateW-1:0]     rate;
  logic [RateW:0]       ssum;
  logic [7:0]           sc;
  logic [SpeedW:0]      spd_add;
  logic                 is_tick;
  logic                 do_clear;

  // Shared front-end arithmetic of a tick.
  assign psum      = {2'b00, pacc_r} + {1'b0, speed_r};
  assign carry     = |psum[PhaseAccW+1:PhaseAccW];
  assign steps_inc = steps_r + {31'd0, carry};
  assign guard_hit = guard_r && (steps_inc > ({16'd0, mlen_r} + GUARD_MARGIN));
  assign phase_g   = guard_hit ? PH_STOP : phase_r;
  assign smode_g   = guard_hit ? 1'b0 : smode_r;
  assign remaining = {16'd0, mlen_r} - steps_inc;
  assign short_left = remaining < ramp_r;
  assign diff      = (speed_r >= tgt_r) ? speed_r - tgt_r : tgt_r - speed_r;
  assign in_band   = diff <= SPEED_TOLERANCE;
  // One speed accumulator adder serves both ramps; the carry is the speed change.
  // The registered phase selects the rate, since a guard stop never uses the sum.
  assign rate      = (phase_r == PH_ACCEL) ? up_r : dn_r;
  assign ssum      = {8'd0, sacc_r} + {1'b0, rate};
  assign sc        = ssum[RateW:SpeedW];
  assign spd_add   = {1'b0, speed_r} + {10'd0, sc};
  assign is_tick   = en && !item.kind;

  always_comb begin
    phase_nxt = phase_r;
    pacc_nxt  = pacc_r;
    sacc_nxt  = sacc_r;
    speed_nxt = speed_r;
    steps_nxt = steps_r;
    ramp_nxt  = ramp_r;
    mlen_nxt  = mlen_r;
    mhalf_nxt = mhalf_r;
    pos_nxt   = pos_r;
    dir_nxt   = dir_r;
    busy_nxt  = busy_r;
    tgt_nxt   = tgt_r;
    up_nxt    = up_r;
    dn_nxt    = dn_r;
    smode_nxt = smode_r;
    guard_nxt = guard_r;
    gflag_nxt = gflag_r;
    do_clear  = 1'b0;

    if (en && item.kind) begin
      if (item.step_total != '0) begin
        dir_nxt   = item.direction;
        busy_nxt  = 1'b1;
        mlen_nxt  = item.step_total;
        mhalf_nxt = item.step_total[MoveW-1:1];
        tgt_nxt   = cfg.max_speed;
        up_nxt    = cfg.accel_rate_up;
        dn_nxt    = cfg.accel_rate_down;
        smode_nxt = cfg.speed_mode;
        guard_nxt = cfg.overrun_guard;
        phase_nxt = PH_ACCEL;
        pacc_nxt  = '0;
        sacc_nxt  = '0;
        ramp_nxt  = '0;
        speed_nxt = '0;
        steps_nxt = '0;
        pos_nxt   = '0;
      end
    end else if (is_tick) begin
      pacc_nxt  = psum[PhaseAccW-1:0];
      steps_nxt = steps_inc;
      // A pulse while idle is counted but does not move the position.
      if (carry && (phase_r != PH_IDLE)) begin
        pos_nxt = dir_r ? pos_r - 32'd1 : pos_r + 32'd1;
      end
      if (guard_hit) begin
        phase_nxt = PH_STOP;
        smode_nxt = 1'b0;
        gflag_nxt = 1'b1;
      end
      if (smode_g && in_band) begin
        if (short_left) begin
          speed_nxt = SPEED_FALLBACK;
          tgt_nxt   = SPEED_FALLBACK;
        end
      end else begin
        case (phase_g)
          PH_ACCEL: begin
            ramp_nxt = ramp_r + {31'd0, carry};
            sacc_nxt = ssum[SpeedW-1:0];
            if (!smode_g) begin
              if (mhalf_r != '0) begin
                if (steps_inc > {17'd0, mhalf_r}) phase_nxt = PH_DECEL;
              end else if (steps_inc != '0) begin
                phase_nxt = PH_DECEL;
              end
            end
            if (spd_add >= {1'b0, tgt_r}) begin
              speed_nxt = tgt_r;
              phase_nxt = PH_MAX;
            end else begin
              speed_nxt = spd_add[SpeedW-1:0];
            end
          end
          PH_MAX: begin
            if (short_left) phase_nxt = PH_DECEL;
          end
          PH_DECEL: begin
            if (carry && (ramp_r != '0)) ramp_nxt = ramp_r - 32'd1;
            sacc_nxt = ssum[SpeedW-1:0];
            if ((sc != '0) && (speed_r > {9'd0, sc})) speed_nxt = speed_r - {9'd0, sc};
            if (!smode_g && (steps_inc >= {16'd0, mlen_r})) begin
              do_clear  = 1'b1;
              steps_nxt = '0;
            end
          end
          PH_STOP: begin
            do_clear  = 1'b1;
            guard_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      if (do_clear) begin
        phase_nxt = PH_IDLE;
        busy_nxt  = 1'b0;
        dir_nxt   = 1'b0;
        smode_nxt = 1'b0;
        mlen_nxt  = '0;
        mhalf_nxt = '0;
        tgt_nxt   = '0;
        up_nxt    = '0;
        dn_nxt    = '0;
        pacc_nxt  = '0;
        sacc_nxt  = '0;
        ramp_nxt  = '0;
        speed_nxt = '0;
        pos_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pacc_r  <= '0;
      sacc_r  <= '0;
      speed_r <= '0;
      steps_r <= '0;
      ramp_r  <= '0;
      mlen_r  <= '0;
      mhalf_r <= '0;
      pos_r   <= '0;
      dir_r   <= 1'b0;
      busy_r  <= 1'b0;
      tgt_r   <= '0;
      up_r    <= '0;
      dn_r    <= '0;
      smode_r <= 1'b0;
      guard_r <= 1'b0;
      gflag_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pacc_r  <= pacc_nxt;
      sacc_r  <= sacc_nxt;
      speed_r <= speed_nxt;
      steps_r <= steps_nxt;
      ramp_r  <= ramp_nxt;
      mlen_r  <= mlen_nxt;
      mhalf_r <= mhalf_nxt;
      pos_r   <= pos_nxt;
      dir_r   <= dir_nxt;
      busy_r  <= busy_nxt;
      tgt_r   <= tgt_nxt;
      up_r    <= up_nxt;
      dn_r    <= dn_nxt;
      smode_r <= smode_nxt;
      guard_r <= guard_nxt;
      gflag_r <= gflag_nxt;
    end
  end

  assign res.step_pulse    = is_tick && carry;
  assign res.position      = $signed(pos_nxt);
  assign res.phase         = phase_nxt;
  assign res.running       = busy_nxt;
  assign res.guard_tripped = gflag_nxt;
  assign res.current_speed = speed_nxt;

endmodule

>>> rtl/stepper_spta_ramp_generator.sv
// Top level of the SPTA stepper ramp generator: input stage, motion core, result register.
//
//   Channel   Direction  Handshake            Payload
//   in_       in         in_valid / in_stall  in_item_t  (kind, direction, step_total)
//   out_      out        out_valid/ out_stall out_item_t (one result per input beat)
//   cfg_      in         cfg_we               cfg_index, cfg_wdata (write only)
//
// Every input beat yields one result beat; an accepted beat is registered in the input
// stage, then its result is registered in the result register, which drives out_valid.
// One beat is accepted per cycle; the state update of a beat is combinational logic
// in the motion core, so nothing limits the rate but output stalls.
// While a result waits under out_stall, one more beat is still taken into the input stage.
// rst_n is synchronous; after reset the block is idle and all counters are zero.
`timescale 1ns / 1ps
module stepper_spta_ramp_generator
  import spta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_valid_r, item_valid_nxt;
  out_item_t res;
  out_item_t res_r;
  logic      res_valid_r, res_valid_nxt;
  logic      out_ready;
  logic      take;
  logic      process;

  assign out_ready = !res_valid_r || !out_stall;
  assign in_stall  = item_valid_r && !out_ready;
  assign take      = in_valid && !in_stall;
  assign process   = item_valid_r && out_ready;

  assign item_valid_nxt = take || (item_valid_r && !out_ready);
  assign res_valid_nxt  = process || (res_valid_r && out_stall);

  spta_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spta_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (process),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
    if (process) begin
      res_r <= res;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

>>> rtl/spta_checker.sv
// Port-level checker for the SPTA stepper ramp generator, bound to the top level.
`timescale 1ns / 1ps
module spta_checker
  import spta_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A reset leaves no result beat pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The running flag and the phase must agree; the stop phase never reaches a result.
  a_running_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.running == (out_data.phase != PH_IDLE)))
    else $error("running flag disagrees with phase");

  // An idle result has no speed and no position.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase == PH_IDLE) |->
      (out_data.current_speed == '0) && (out_data.position == '0))
    else $error("idle result with nonzero speed or position");

  a_guard_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.guard_tripped |=> out_data.guard_tripped)
    else $error("guard tripped flag cleared without reset");

endmodule

bind stepper_spta_ramp_generator spta_checker u_spta_checker (.*);

>>> test/stepper_spta_ramp_generator_tb.sv
// Self-checking testbench for the SPTA stepper ramp generator, with its own motion predictor.
`timescale 1ns / 1ps
module stepper_spta_ramp_generator_tb;
  import spta_pkg::*;

  localparam int QuietLimit = 2000;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  stepper_spta_ramp_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted motor state, kept in 32-bit words so wraps match the block.
  cfg_t        cfg_shadow;
  logic [2:0]  m_phase;
  logic [31:0] m_phase_acc, m_speed_acc, m_speed, m_done, m_ramp, m_len, m_half, m_pos;
  logic [31:0] m_target, m_up, m_down;
  logic        m_dir, m_busy, m_smode, m_guard, m_gflag;

  out_item_t   predicted_status[$];
  int          items_sent   = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          no_gaps      = 1'b0;

  function automatic void clear_motion();
    m_phase = PH_IDLE;
    m_busy = 1'b0; m_dir = 1'b0; m_smode = 1'b0;
    m_len = '0; m_half = '0; m_target = '0; m_up = '0; m_down = '0;
    m_phase_acc = '0; m_speed_acc = '0; m_ramp = '0; m_speed = '0; m_pos = '0;
  endfunction

  function automatic void reset_motor();
    cfg_shadow = '0;
    clear_motion();
    m_done = '0; m_guard = 1'b0; m_gflag = 1'b0;
  endfunction

  // Adds a rate into the 17-bit speed accumulator and returns the carry amount.
  function automatic logic [31:0] ramp_carry(input logic [31:0] rate);
    logic [31:0] sum;
    sum = m_speed_acc + rate;
    m_speed_acc = sum & 32'h1FFFF;
    return sum >> 17;
  endfunction

  function automatic logic motor_tick();
    logic [31:0] sum, sc, gap;
    logic        carry;
    sum = m_phase_acc + m_speed;
    carry = (sum >> 16) != 0;
    m_phase_acc = sum & 32'hFFFF;
    if (carry) begin
      m_done = m_done + 1;
      if (m_phase != PH_IDLE) m_pos = m_dir ? m_pos - 1 : m_pos + 1;
    end
    if (m_guard && m_done > m_len + GUARD_MARGIN) begin
      m_phase = PH_STOP;
      m_smode = 1'b0;
      m_gflag = 1'b1;
    end
    if (m_smode) begin
      gap = (m_speed >= m_target) ? m_speed - m_target : m_target - m_speed;
      if (gap <= 32'(SPEED_TOLERANCE)) begin
        if (m_len - m_done < m_ramp) begin
          m_speed = 32'(SPEED_FALLBACK);
          m_target = 32'(SPEED_FALLBACK);
        end
        return carry;
      end
    end
    case (m_phase)
      PH_ACCEL: begin
        if (carry) m_ramp = m_ramp + 1;
        m_speed = m_speed + ramp_carry(m_up);
        if (!m_smode) begin
          if (m_half != 0) begin
            if (m_done > m_half) m_phase = PH_DECEL;
          end else if (m_done > 0) begin
            m_phase = PH_DECEL;
          end
        end
        if (m_speed >= m_target) begin
          m_speed = m_target;
          m_phase = PH_MAX;
        end
      end
      PH_MAX: begin
        if (m_len - m_done < m_ramp) m_phase = PH_DECEL;
      end
      PH_DECEL: begin
        if (carry && m_ramp > 0) m_ramp = m_ramp - 1;
        sc = ramp_carry(m_down);
        if (sc != 0 && m_speed > sc) m_speed = m_speed - sc;
        if (!m_smode && m_done >= m_len) begin
          clear_motion();
          m_done = '0;
        end
      end
      PH_STOP: begin
        clear_motion();
        m_guard = 1'b0;
      end
      default: ;
    endcase
    return carry;
  endfunction

  function automatic out_item_t advance_motor(input in_item_t item);
    out_item_t status;
    logic      pulse;
    pulse = 1'b0;
    if (item.kind) begin
      if (item.step_total != '0) begin
        m_dir = item.direction;
        m_busy = 1'b1;
        m_len = 32'(item.step_total);
        m_half = 32'(item.step_total) >> 1;
        m_target = 32'(cfg_shadow.max_speed);
        m_up = 32'(cfg_shadow.accel_rate_up);
        m_down = 32'(cfg_shadow.accel_rate_down);
        m_smode = cfg_shadow.speed_mode;
        m_guard = cfg_shadow.overrun_guard;
        m_phase = PH_ACCEL;
        m_phase_acc = '0; m_speed_acc = '0; m_ramp = '0;
        m_speed = '0; m_done = '0; m_pos = '0;
      end
    end else begin
      pulse = motor_tick();
    end
    status.step_pulse    = pulse;
    status.position      = m_pos;
    status.phase         = m_phase;
    status.running       = m_busy;
    status.guard_tripped = m_gflag;
    status.current_speed = m_speed[SpeedW-1:0];
    return status;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                              results_seen, field, got, want));
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (out_valid && !out_stall) begin
      if (predicted_status.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = predicted_status.pop_front();
        compare_field("step_pulse", 32'(out_data.step_pulse), 32'(want.step_pulse));
        compare_field("position", out_data.position, want.position);
        compare_field("phase", 32'(out_data.phase), 32'(want.phase));
        compare_field("running", 32'(out_data.running), 32'(want.running));
        compare_field("guard_tripped", 32'(out_data.guard_tripped),
                      32'(want.guard_tripped));
        compare_field("current_speed", 32'(out_data.current_speed),
                      32'(want.current_speed));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 36);
  end

  // Ends the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("stepper_spta_ramp_generator_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(input logic kind, input logic dir,
                                         input logic [MoveW-1:0] total);
    in_item_t item;
    item.kind = kind;
    item.direction = dir;
    item.step_total = total;
    return item;
  endfunction

  // A tick carries random content in the fields it does not use.
  function automatic in_item_t random_tick();
    return make_item(1'b0, 1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)));
  endfunction

  task automatic send_item(input in_item_t item);
    while (!no_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_status.push_back(advance_motor(item));
    if (!item.kind || item.step_total != '0) items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Registers only change while no beat is in flight.
  task automatic program_config(input cfg_t c);
    wait_drain();
    write_reg(CFG_MAX_SPEED, CfgDataW'(c.max_speed));
    write_reg(CFG_ACCEL_UP, c.accel_rate_up);
    write_reg(CFG_ACCEL_DOWN, c.accel_rate_down);
    write_reg(CFG_SPEED_MODE, CfgDataW'(c.speed_mode));
    write_reg(CFG_GUARD, CfgDataW'(c.overrun_guard));
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  // Mostly whole moves: a start, then ticks until the move ends or gets cut short.
  task automatic run_moves(input int budget, input int total_hi, input int cap_hi);
    int       stop_at;
    int       cap;
    in_item_t item;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(9) == 0)
          item = make_item(1'b1, 1'($urandom_range(1, 0)), 16'($urandom_range(65535, 1)));
        else
          item = make_item(1'b1, 1'($urandom_range(1, 0)), 16'($urandom_range(total_hi, 1)));
        send_item(item);
        cap = $urandom_range(cap_hi, 10);
        while (m_phase != PH_IDLE && cap > 0 && items_sent < stop_at) begin
          send_item(random_tick());
          cap--;
        end
      end else begin
        item = make_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                         16'($urandom_range(65535, 0)));
        if ($urandom_range(3) == 0) item.step_total = '0;
        send_item(item);
      end
    end
  endtask

  task automatic test_directed_edges();
    program_config('0);
    send_item(random_tick());
    send_item(make_item(1'b1, 1'b1, 16'd0));
    send_item(make_item(1'b1, 1'b1, 16'hFFFF));
    repeat (2) send_item(random_tick());
    program_config(cfg_t'{17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0});
    send_item(make_item(1'b1, 1'b0, 16'd0));
    send_item(make_item(1'b1, 1'b0, 16'd1));
    repeat (18) send_item(random_tick());
  endtask

  task automatic test_fast_positioning();
    program_config(cfg_t'{17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1});
    run_moves(100, 6, 300);
  endtask

  task automatic test_capped_speed();
    program_config(cfg_t'{17'd5000, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0});
    run_moves(200, 8, 250);
  endtask

  task automatic test_speed_mode_band();
    cfg_t c;
    c.max_speed = 17'($urandom_range(30000, 8000));
    c.accel_rate_up = 24'hFFFFFF;
    c.accel_rate_down = 24'($urandom_range(24'hFFFFFF, 0));
    c.speed_mode = 1'b1;
    c.overrun_guard = 1'b0;
    program_config(c);
    run_moves(250, 60, 300);
  endtask

  task automatic test_zero_config();
    program_config('0);
    run_moves(30, 65535, 20);
  endtask

  // Speed mode never finishes a move, so the guard has to stop it; the speed
  // passes 65535 on the way, which gives ticks whose phase sum carries twice.
  task automatic test_overrun_guard();
    int n;
    program_config(cfg_t'{17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1});
    no_gaps = 1'b1;
    send_item(make_item(1'b1, 1'b1, 16'd1));
    n = 0;
    while (m_phase != PH_IDLE && n < 3000) begin
      if (n == 250) no_gaps = 1'b0;
      send_item(random_tick());
      n++;
    end
    no_gaps = 1'b0;
    repeat (6) send_item(random_tick());
    send_item(make_item(1'b1, 1'b0, 16'd3));
    repeat (10) send_item(random_tick());
  endtask

  initial begin
    reset_motor();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_fast_positioning();
    test_capped_speed();
    test_speed_mode_band();
    test_zero_config();
    test_overrun_guard();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("stepper_spta_ramp_generator_tb: clean");
    end else begin
      $display("stepper_spta_ramp_generator_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/spta_pkg.sv
rtl/spta_cfg_regs.sv
rtl/spta_core.sv
rtl/stepper_spta_ramp_generator.sv
rtl/spta_checker.sv
test/stepper_spta_ramp_generator_tb.sv
